FILE: rtl/cht_pkg.sv
// Shared types, codes and constants for the chained hash table.
// No dependencies; compiled first.
package cht_pkg;

	localparam int KEY_W       = 31;
	localparam int VAL_W       = 32;
	localparam int CFG_W       = 7;
	localparam int CMD_W       = 2;
	localparam int STS_W       = 2;
	localparam int PROD_W      = 35;  // key * 13 needs four extra bits
	localparam int HCNT_W      = 6;
	localparam int DEF_BUCKETS = 64;
	localparam int DEF_NODES   = 64;
	localparam int HASH_MUL    = 13;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

	localparam logic [STS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STS_W-1:0] ST_POOL_FULL = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic             clr_en;
		logic             load;
		logic             hash_step;
		logic             head_rd;
		logic             walk_init;
		logic             node_rd;
		logic             walk_adv;
		logic             walk_hit;
		logic             pop_rd;
		logic             alloc;
		logic             link_ins;
		logic             upd;
		logic             rm;
		logic             res_load;
		logic             res_val;
		logic [STS_W-1:0] res_status;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic             clr_last;
		logic             hash_last;
		logic             cur_nil;
		logic             steps_max;
		logic             key_match;
		logic             found;
		logic             fc_zero;
		logic             out_free;
		logic [CMD_W-1:0] command;
	} sts_t;

endpackage

FILE: rtl/cht_if.sv
// Handshake channels of the chained hash table: request, response, configuration.
// Depends on cht_pkg.
interface cht_req_if;
	logic                              valid;
	logic                              ready;
	logic [cht_pkg::CMD_W-1:0]         command;
	logic [cht_pkg::KEY_W-1:0]         key;
	logic signed [cht_pkg::VAL_W-1:0]  value;
	modport source (output valid, command, key, value, input ready);
	modport sink   (input valid, command, key, value, output ready);
endinterface

interface cht_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [cht_pkg::STS_W-1:0]         status;
	logic signed [cht_pkg::VAL_W-1:0]  found_value;
	modport source (output valid, status, found_value, input ready);
	modport sink   (input valid, status, found_value, output ready);
endinterface

interface cht_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cht_pkg::CFG_W-1:0]         data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/cht_datapath.sv
// Datapath: hash remainder unit, chain pointers, node/bucket/free memories, result register.
// Depends on cht_pkg; driven by cht_ctrl through ctl_t.
module cht_datapath #(
	parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
	parameter int NODES   = cht_pkg::DEF_NODES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cht_pkg::ctl_t                    ctl,
	output cht_pkg::sts_t                    sts,
	input  logic [cht_pkg::CMD_W-1:0]        req_command,
	input  logic [cht_pkg::KEY_W-1:0]        req_key,
	input  logic signed [cht_pkg::VAL_W-1:0] req_value,
	input  logic                             cfg_valid,
	input  logic [cht_pkg::CFG_W-1:0]        cfg_data,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [cht_pkg::STS_W-1:0]        rsp_status,
	output logic signed [cht_pkg::VAL_W-1:0] rsp_value
);
	import cht_pkg::*;

	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam int MAXM    = (BUCKETS > CFG_MAX) ? BUCKETS : CFG_MAX;
	localparam int MW      = $clog2(MAXM + 1);
	localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int PW      = $clog2(NODES + 1);
	localparam int NI      = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int MAXBN   = (BUCKETS > NODES) ? BUCKETS : NODES;
	localparam int CW      = $clog2(MAXBN + 1);
	localparam int KVW     = KEY_W + VAL_W;
	localparam logic [PW-1:0] NIL = PW'(NODES);

	logic [PW-1:0]  head_mem [BUCKETS];
	logic [PW-1:0]  next_mem [NODES];
	logic [KVW-1:0] kv_mem   [NODES];
	logic [NI-1:0]  fs_mem   [NODES];

	logic [MW-1:0]     m_q;
	logic [CW-1:0]     clr_q;
	logic [PROD_W-1:0] prod_q;
	logic [MW-1:0]     rem_q;
	logic [HCNT_W-1:0] hcnt_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [PW-1:0]     cur_q, prev_q, steps_q, head_rd_q, next_rd_q;
	logic [KVW-1:0]    kv_rd_q;
	logic [NI-1:0]     fs_rd_q, new_q;
	logic [PW-1:0]     fc_q;
	logic              found_q;
	logic              out_valid_q;
	logic [STS_W-1:0]  out_status_q;
	logic [VAL_W-1:0]  out_value_q;

	logic [MW:0]    trial;
	logic [BW-1:0]  bucket;
	logic [NI-1:0]  cur_idx, prev_idx;
	logic           prev_nil;

	assign trial    = {rem_q, prod_q[PROD_W-1]};
	assign bucket   = BW'(rem_q);
	assign cur_idx  = cur_q[NI-1:0];
	assign prev_idx = prev_q[NI-1:0];
	assign prev_nil = (prev_q >= NIL);

	// modulus, saturated to BUCKETS on write; zero is taken as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= MW'(BUCKETS);
		end else if (cfg_valid) begin
			if (cfg_data == '0)
				m_q <= MW'(1);
			else if (MW'(cfg_data) > MW'(BUCKETS))
				m_q <= MW'(BUCKETS);
			else
				m_q <= MW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			fc_q        <= PW'(NODES);
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_en)
				clr_q <= clr_q + CW'(1);
			if (ctl.walk_init)
				found_q <= 1'b0;
			else if (ctl.walk_hit)
				found_q <= 1'b1;
			if (ctl.alloc)
				fc_q <= fc_q - PW'(1);
			else if (ctl.rm && fc_q < PW'(NODES))
				fc_q <= fc_q + PW'(1);
			if (ctl.res_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// request latch, restoring remainder one bit a cycle, walk pointers, new node, result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= req_command;
			key_q  <= req_key;
			val_q  <= req_value;
			prod_q <= (PROD_W'(req_key) << 3) + (PROD_W'(req_key) << 2) + PROD_W'(req_key);
			rem_q  <= '0;
			hcnt_q <= '0;
		end else if (ctl.hash_step) begin
			prod_q <= prod_q << 1;
			hcnt_q <= hcnt_q + HCNT_W'(1);
			if (trial >= {1'b0, m_q})
				rem_q <= MW'(trial - {1'b0, m_q});
			else
				rem_q <= trial[MW-1:0];
		end
		if (ctl.walk_init) begin
			cur_q   <= head_rd_q;
			prev_q  <= NIL;
			steps_q <= '0;
		end else if (ctl.walk_adv) begin
			prev_q  <= cur_q;
			cur_q   <= next_rd_q;
			steps_q <= steps_q + PW'(1);
		end
		if (ctl.alloc)
			new_q <= fs_rd_q;
		if (ctl.res_load) begin
			out_status_q <= ctl.res_status;
			out_value_q  <= ctl.res_val ? kv_rd_q[VAL_W-1:0] : '0;
		end
	end

	// bucket heads
	always_ff @(posedge clk) begin
		if (ctl.clr_en && clr_q < CW'(BUCKETS))
			head_mem[BW'(clr_q)] <= NIL;
		else if (ctl.link_ins && prev_nil)
			head_mem[bucket] <= PW'(new_q);
		else if (ctl.rm && prev_nil)
			head_mem[bucket] <= next_rd_q;
		if (ctl.head_rd)
			head_rd_q <= head_mem[bucket];
	end

	// next links
	always_ff @(posedge clk) begin
		if (ctl.alloc)
			next_mem[fs_rd_q] <= NIL;
		else if (ctl.link_ins && !prev_nil)
			next_mem[prev_idx] <= PW'(new_q);
		else if (ctl.rm && !prev_nil)
			next_mem[prev_idx] <= next_rd_q;
		if (ctl.node_rd)
			next_rd_q <= next_mem[cur_idx];
	end

	// key and value words
	always_ff @(posedge clk) begin
		if (ctl.alloc)
			kv_mem[fs_rd_q] <= {key_q, val_q};
		else if (ctl.upd)
			kv_mem[cur_idx] <= {key_q, val_q};
		if (ctl.node_rd)
			kv_rd_q <= kv_mem[cur_idx];
	end

	// free stack
	always_ff @(posedge clk) begin
		if (ctl.clr_en && clr_q < CW'(NODES))
			fs_mem[NI'(clr_q)] <= NI'(NODES - 1) - NI'(clr_q);
		else if (ctl.rm && fc_q < PW'(NODES))
			fs_mem[NI'(fc_q)] <= cur_idx;
		if (ctl.pop_rd)
			fs_rd_q <= fs_mem[NI'(fc_q - PW'(1))];
	end

	assign sts.clr_last  = (clr_q == CW'(MAXBN - 1));
	assign sts.hash_last = (hcnt_q == HCNT_W'(PROD_W - 1));
	assign sts.cur_nil   = (cur_q >= NIL);
	assign sts.steps_max = (steps_q == PW'(NODES));
	assign sts.key_match = (kv_rd_q[KVW-1:VAL_W] == key_q);
	assign sts.found     = found_q;
	assign sts.fc_zero   = (fc_q == '0);
	assign sts.out_free  = !out_valid_q || rsp_ready;
	assign sts.command   = cmd_q;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_value  = out_value_q;

endmodule

FILE: rtl/cht_ctrl.sv
// Controller state machine: clearing sweep, hash, chain walk, command action, result hand-off.
// Depends on cht_pkg; steers cht_datapath through ctl_t.
module cht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cht_pkg::sts_t sts,
	output cht_pkg::ctl_t ctl
);
	import cht_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_HEAD = 4'd3;
	localparam logic [3:0] S_HDW  = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_CMP  = 4'd6;
	localparam logic [3:0] S_ACT  = 4'd7;
	localparam logic [3:0] S_POP  = 4'd8;
	localparam logic [3:0] S_LINK = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]       state_q, state_d;
	logic [STS_W-1:0] st_q, st_d;
	logic             rv_q, rv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			st_q    <= ST_OK;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rv_q    <= rv_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		rv_d    = rv_q;
		ctl     = '0;
		ctl.res_status = st_q;
		ctl.res_val    = rv_q;
		unique case (state_q)
			S_CLR: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				ctl.hash_step = 1'b1;
				if (sts.hash_last)
					state_d = S_HEAD;
			end
			S_HEAD: begin
				ctl.head_rd = 1'b1;
				state_d     = S_HDW;
			end
			S_HDW: begin
				ctl.walk_init = 1'b1;
				state_d       = S_CHK;
			end
			S_CHK: begin
				if (sts.cur_nil || sts.steps_max) begin
					state_d = S_ACT;
				end else begin
					ctl.node_rd = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.key_match) begin
					ctl.walk_hit = 1'b1;
					state_d      = S_ACT;
				end else begin
					ctl.walk_adv = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_ACT: begin
				rv_d    = 1'b0;
				st_d    = sts.found ? ST_OK : ST_NOT_FOUND;
				state_d = S_FIN;
				case (sts.command)
					CMD_LOOKUP: rv_d = sts.found;
					CMD_INSERT: begin
						if (sts.found) begin
							st_d = ST_DUPLICATE;
						end else if (sts.fc_zero) begin
							st_d = ST_POOL_FULL;
						end else begin
							ctl.pop_rd = 1'b1;
							st_d       = ST_OK;
							state_d    = S_POP;
						end
					end
					CMD_UPDATE: ctl.upd = sts.found;
					default: begin
						ctl.rm = sts.found;
						rv_d   = sts.found;
					end
				endcase
			end
			S_POP: begin
				ctl.alloc = 1'b1;
				state_d   = S_LINK;
			end
			S_LINK: begin
				ctl.link_ins = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

endmodule

FILE: rtl/chained_hash_table_top.sv
// Top level of the chained hash table: wires controller, datapath and the three channels.
// Depends on cht_pkg, cht_if, cht_datapath, cht_ctrl.
//
//  channel | dir | beat carries
//  --------+-----+-------------------------------------------
//  req     | in  | command, key, value (one request per beat)
//  rsp     | out | status, found_value (one beat per request)
//  cfg     | in  | data: bucket_count, always ready
//
// A request passes through: accept, bit-serial hash (remainder of key*13 by
// the bucket count), head read, a check and a compare per chain node visited
// (and a final check when the walk runs off the end of the chain), action (plus
// pop and link for an insert that allocates), result load.
// Reset starts a clearing sweep that empties the
// bucket heads and fills the free stack; no request is taken meanwhile.
// A finished result sits in the output register; the next request is taken
// while it waits, and only the load of its own result stalls on rsp.ready.
module chained_hash_table_top #(
	parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
	parameter int NODES   = cht_pkg::DEF_NODES
) (
	input logic         clk,
	input logic         arst_n,
	cht_req_if.sink     req,
	cht_rsp_if.source   rsp,
	cht_cfg_if.sink     cfg
);
	import cht_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// configuration is a single register, taken on any cycle
	assign cfg.ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	cht_datapath #(
		.BUCKETS (BUCKETS),
		.NODES   (NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.req_command (req.command),
		.req_key     (req.key),
		.req_value   (req.value),
		.cfg_valid   (cfg.valid),
		.cfg_data    (cfg.data),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_status  (rsp.status),
		.rsp_value   (rsp.found_value)
	);

endmodule
